// File: hw/rtl/neighbor_table_with_aging_top_assert.svh
// Assertion macros shared by the neighbor table RTL.
`ifndef NEIGHBOR_TABLE_WITH_AGING_TOP_ASSERT_SVH
`define NEIGHBOR_TABLE_WITH_AGING_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NTA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define NTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NTA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define NTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/nta_pkg.sv
// Package: constants, codes and the command beat type of the neighbor table.
package nta_pkg;
  localparam int TableDepth = 16;
  localparam int IfaceCount = 4;
  localparam int SlotW = $clog2(TableDepth);
  localparam int IfcNumW = $clog2(IfaceCount);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam logic [7:0] DeadReset = 8'd15;

  localparam logic [2:0] EV_REFRESH = 3'd0;
  localparam logic [2:0] EV_ADDED = 3'd1;
  localparam logic [2:0] EV_EXPIRED = 3'd2;
  localparam logic [2:0] EV_FULL = 3'd3;
  localparam logic [2:0] EV_QUIET = 3'd4;

  localparam logic FUNC_HELLO = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic func;
    logic [1:0] iface;
    logic [31:0] rid;
    logic [31:0] addr;
    logic [31:0] mask;
  } cmd_t;
endpackage

// File: hw/rtl/nta_front.sv
// Front end: accept a command beat and hold it in a two-entry queue.
module nta_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  nta_pkg::cmd_t cmd_in,
  output logic          full,
  output logic          q_valid,
  output nta_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import nta_pkg::*;
  cmd_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push;

  assign full = (cnt == 2'd2);
  assign push = start && !full;
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= cmd_in;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  `include "neighbor_table_with_aging_top_assert.svh"
  `NTA_ASSERT_IMPL(a_no_pop_empty, clk, rst, q_pop, q_valid, "pop from empty queue")
  `NTA_ASSERT_IMPL(a_cnt_range, clk, rst, 1'b1, cnt != 2'd3, "queue count out of range")
  `NTA_ASSERT_NEXT(a_push_grows, clk, rst, push && !q_pop, cnt != 2'd0, "push lost")
endmodule

// File: hw/rtl/nta_back.sv
// Back end: walk the table slot by slot for each command and emit results.
module nta_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    dead_ticks,
  input  logic          q_valid,
  input  nta_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          done,
  output logic [2:0]    event_res,
  output logic [1:0]    out_iface,
  output logic [31:0]   out_router_id,
  output logic [31:0]   out_addr,
  output logic [31:0]   out_mask,
  output logic [4:0]    iface_count,
  output logic          last,
  output logic          tick_end
);
  import nta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state;
  cmd_t cur;
  logic [SlotW-1:0] slot;
  logic [TableDepth-1:0] valid;
  logic [1:0] e_ifc [TableDepth];
  logic [31:0] e_rid [TableDepth];
  logic [31:0] e_addr [TableDepth];
  logic [31:0] e_mask [TableDepth];
  logic [7:0] e_alive [TableDepth];
  logic [CntW-1:0] ncount [IfaceCount];
  logic have_free;
  logic [SlotW-1:0] free_slot;
  logic any_exp;

  logic sv;
  logic [1:0] s_ifc;
  logic [31:0] s_rid, s_addr, s_mask;
  logic [7:0] s_alive;
  logic is_last_slot, hit, ifc_ok;
  logic [IfcNumW-1:0] cifc, sifc;
  logic [CntW-1:0] ccnt, scnt_dec;

  always_comb begin
    sv = valid[slot];
    s_ifc = e_ifc[slot];
    s_rid = e_rid[slot];
    s_addr = e_addr[slot];
    s_mask = e_mask[slot];
    s_alive = e_alive[slot];
    is_last_slot = (slot == SlotW'(TableDepth - 1));
    ifc_ok = ({30'd0, cur.iface} < 32'(IfaceCount));
    cifc = IfcNumW'(cur.iface);
    sifc = IfcNumW'(s_ifc);
    ccnt = ifc_ok ? ncount[cifc] : '0;
    scnt_dec = ncount[sifc] - CntW'(1);
    hit = sv && (s_ifc == cur.iface) && (s_rid == cur.rid);
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      for (int i = 0; i < IfaceCount; i++) ncount[i] <= '0;
      slot <= '0;
      have_free <= 1'b0;
      free_slot <= '0;
      any_exp <= 1'b0;
      done <= 1'b0;
      last <= 1'b0;
      tick_end <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          tick_end <= 1'b0;
          if (q_valid) begin
            cur <= q_cmd;
            slot <= '0;
            have_free <= 1'b0;
            any_exp <= 1'b0;
            if (q_cmd.func == FUNC_HELLO &&
                !({30'd0, q_cmd.iface} < 32'(IfaceCount))) begin
              done <= 1'b1;
              last <= 1'b1;
              event_res <= EV_FULL;
              out_iface <= q_cmd.iface;
              out_router_id <= q_cmd.rid;
              out_addr <= q_cmd.addr;
              out_mask <= q_cmd.mask;
              iface_count <= '0;
            end else begin
              done <= 1'b0;
              last <= 1'b0;
              state <= S_SCAN;
            end
          end else begin
            done <= 1'b0;
            last <= 1'b0;
          end
        end
        S_SCAN: begin
          tick_end <= 1'b0;
          if (cur.func == FUNC_TICK) begin
            last <= 1'b0;
            if (sv && s_alive > 8'd1) begin
              e_alive[slot] <= s_alive - 8'd1;
              done <= 1'b0;
            end else if (sv) begin
              // Drop the slot and report it.
              valid[slot] <= 1'b0;
              any_exp <= 1'b1;
              ncount[sifc] <= scnt_dec;
              done <= 1'b1;
              event_res <= EV_EXPIRED;
              out_iface <= s_ifc;
              out_router_id <= s_rid;
              out_addr <= s_addr;
              out_mask <= s_mask;
              iface_count <= 5'(scnt_dec);
            end else begin
              done <= 1'b0;
            end
            if (is_last_slot) state <= S_FIN;
            else slot <= slot + SlotW'(1);
          end else begin
            if (hit) begin
              e_alive[slot] <= dead_ticks;
              done <= 1'b1;
              last <= 1'b1;
              event_res <= EV_REFRESH;
              out_iface <= cur.iface;
              out_router_id <= cur.rid;
              out_addr <= s_addr;
              out_mask <= s_mask;
              iface_count <= 5'(ccnt);
              state <= S_IDLE;
            end else begin
              done <= 1'b0;
              last <= 1'b0;
              if (!sv && !have_free) begin
                have_free <= 1'b1;
                free_slot <= slot;
              end
              if (is_last_slot) state <= S_FIN;
              else slot <= slot + SlotW'(1);
            end
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          if (cur.func == FUNC_TICK) begin
            // Close the tick: flag the end of the expiries or report a quiet tick.
            if (any_exp) begin
              done <= 1'b0;
              last <= 1'b0;
              tick_end <= 1'b1;
            end else begin
              done <= 1'b1;
              last <= 1'b1;
              tick_end <= 1'b0;
              event_res <= EV_QUIET;
              out_iface <= '0;
              out_router_id <= '0;
              out_addr <= '0;
              out_mask <= '0;
              iface_count <= '0;
            end
          end else begin
            done <= 1'b1;
            last <= 1'b1;
            tick_end <= 1'b0;
            out_iface <= cur.iface;
            out_router_id <= cur.rid;
            out_addr <= cur.addr;
            out_mask <= cur.mask;
            if (have_free) begin
              valid[free_slot] <= 1'b1;
              e_ifc[free_slot] <= cur.iface;
              e_rid[free_slot] <= cur.rid;
              e_addr[free_slot] <= cur.addr;
              e_mask[free_slot] <= cur.mask;
              e_alive[free_slot] <= dead_ticks;
              ncount[cifc] <= ccnt + CntW'(1);
              event_res <= EV_ADDED;
              iface_count <= 5'(ccnt + CntW'(1));
            end else begin
              event_res <= EV_FULL;
              iface_count <= 5'(ccnt);
            end
          end
        end
        default: begin
          state <= S_IDLE;
          done <= 1'b0;
          last <= 1'b0;
          tick_end <= 1'b0;
        end
      endcase
    end
  end

  `include "neighbor_table_with_aging_top_assert.svh"
  `NTA_ASSERT_IMPL(a_pop_idle, clk, rst, q_pop, state == S_IDLE, "pop outside idle")
  `NTA_ASSERT_NEXT(a_fin_idle, clk, rst, state == S_FIN, state == S_IDLE, "fin must end")
  `NTA_ASSERT_IMPL(a_last_done, clk, rst, last, done, "last without strobe")
  `NTA_ASSERT_IMPL(a_end_quiet, clk, rst, tick_end, !done, "tick end with strobe")
endmodule

// File: hw/rtl/neighbor_table_with_aging_top.sv
// Top level of the neighbor table with dead-interval aging.
// Commands enter on start while busy is low and wait in a two-deep queue;
// busy rises only when two commands are waiting. The back end takes one
// command at a time: it picks the command up in its idle state, walks the
// 16 slots in its scan state, then finishes in its closing state, though a
// hello that hits stops the walk at that slot. A hello answers on a hit or
// after the walk; a tick always walks all 16 slots and gives one expiry
// beat per removed slot, in slot order, or one quiet beat. Each beat goes
// out through the output register. Results appear for exactly one cycle
// on done; the receiver cannot stall them, so each beat must be taken when
// done is high. Because the expiry beats of a tick are emitted during the
// walk, last cannot be known on the beat itself: the result path holds
// each expiry until the next one arrives or the walk ends, and sets last
// on the final one. Configuration of dead_ticks is always ready and takes
// effect for any hello that refreshes or adds an entry after the write.
module neighbor_table_with_aging_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [1:0]  iface_index,
  input  logic [31:0] hello_id,
  input  logic [31:0] source_addr,
  input  logic [31:0] net_mask,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [2:0]  event_res,
  output logic [1:0]  out_iface,
  output logic [31:0] out_router_id,
  output logic [31:0] out_addr,
  output logic [31:0] out_mask,
  output logic [4:0]  iface_count,
  output logic        last
);
  import nta_pkg::*;

  logic [7:0] dead_ticks;
  cmd_t cmd_in, q_cmd;
  logic q_valid, q_pop;
  logic b_done, b_last, b_tick_end;
  logic [2:0] b_ev;
  logic [1:0] b_ifc;
  logic [31:0] b_rid, b_addr, b_mask;
  logic [4:0] b_cnt;
  logic held;
  logic [1:0] h_ifc;
  logic [31:0] h_rid, h_addr, h_mask;
  logic [4:0] h_cnt;

  assign cfg_ready = 1'b1;
  assign cmd_in = '{func: func, iface: iface_index, rid: hello_id,
                    addr: source_addr, mask: net_mask};

  always_ff @(posedge clk) begin
    if (rst) dead_ticks <= DeadReset;
    else if (cfg_valid && cfg_ready) dead_ticks <= cfg_data;
  end

  nta_front u_front (
    .clk(clk), .rst(rst), .start(start), .cmd_in(cmd_in), .full(busy),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  nta_back u_back (
    .clk(clk), .rst(rst), .dead_ticks(dead_ticks), .q_valid(q_valid),
    .q_cmd(q_cmd), .q_pop(q_pop), .done(b_done), .event_res(b_ev),
    .out_iface(b_ifc), .out_router_id(b_rid), .out_addr(b_addr),
    .out_mask(b_mask), .iface_count(b_cnt), .last(b_last),
    .tick_end(b_tick_end)
  );

  // Hold back each expiry beat. A new expiry releases the held one without
  // last; the back end's end-of-walk flag, raised in the cycle after its
  // closing state, releases the final held expiry with last set. Other beats
  // pass straight through the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      done <= 1'b0;
      last <= 1'b0;
    end else if (b_done && b_ev == EV_EXPIRED) begin
      done <= held;
      last <= 1'b0;
      event_res <= EV_EXPIRED;
      out_iface <= h_ifc;
      out_router_id <= h_rid;
      out_addr <= h_addr;
      out_mask <= h_mask;
      iface_count <= h_cnt;
      held <= 1'b1;
      h_ifc <= b_ifc;
      h_rid <= b_rid;
      h_addr <= b_addr;
      h_mask <= b_mask;
      h_cnt <= b_cnt;
    end else if (b_done) begin
      done <= 1'b1;
      last <= b_last;
      event_res <= b_ev;
      out_iface <= b_ifc;
      out_router_id <= b_rid;
      out_addr <= b_addr;
      out_mask <= b_mask;
      iface_count <= b_cnt;
    end else if (held && b_tick_end) begin
      done <= 1'b1;
      last <= 1'b1;
      event_res <= EV_EXPIRED;
      out_iface <= h_ifc;
      out_router_id <= h_rid;
      out_addr <= h_addr;
      out_mask <= h_mask;
      iface_count <= h_cnt;
      held <= 1'b0;
    end else begin
      done <= 1'b0;
    end
  end
endmodule
